@@ hw/rtl/half_open_interval_set_table_defines.svh @@
// ----------------------------------------------------------------------------
// Interval set table assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef HALF_OPEN_INTERVAL_SET_TABLE_DEFINES_SVH
`define HALF_OPEN_INTERVAL_SET_TABLE_DEFINES_SVH

// property must hold at every edge
`define HOIST_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HOIST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hoist_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval set table package
// Request and response types, command and status codes, cell types.
// ----------------------------------------------------------------------------
package hoist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int KW           = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] CMD_INSERT    = 3'd0;
    localparam logic [2:0] CMD_ERASE     = 3'd1;
    localparam logic [2:0] CMD_LOOKUP    = 3'd2;
    localparam logic [2:0] CMD_INTERSECT = 3'd3;
    localparam logic [2:0] CMD_SUBSET    = 3'd4;
    localparam logic [2:0] CMD_TOTAL     = 3'd5;
    localparam logic [2:0] CMD_CLEAR     = 3'd6;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] range_begin;
        logic [63:0] range_end;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [63:0] piece_begin;
        logic [63:0] piece_end;
        logic [63:0] total_length;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_entry;

    typedef struct packed {
        logic ovl;
        logic touch;
        logic strad;
        logic holds;
    } t_flags;

endpackage

@@ hw/rtl/hoist_cell.sv @@
// ----------------------------------------------------------------------------
// Interval set table cell
// Holds one interval, shifts toward the head, compares against the request.
// ----------------------------------------------------------------------------
module hoist_cell
    import hoist_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  logic   i_load,
    input  t_entry i_nbr,
    input  t_entry i_new,
    input  logic [63:0] i_b,
    input  logic [63:0] i_e,
    output t_entry o_q,
    output t_flags o_flags
);

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_new;
        end else if (i_shift) begin
            r_q <= i_nbr;
        end
    end

    always_comb begin
        o_flags.ovl   = (r_q.lo < i_e) && (r_q.hi > i_b);
        o_flags.touch = (r_q.lo <= i_e) && (r_q.hi >= i_b);
        o_flags.strad = (r_q.lo < i_b) && (r_q.hi > i_e);
        o_flags.holds = (r_q.lo <= i_b) && (i_b < r_q.hi);
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/half_open_interval_set_table.sv @@
// ----------------------------------------------------------------------------
// Half-open interval set table
// Sorted set of disjoint intervals held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Requests enter on i_req_valid / o_req_ready, one at a time; responses leave
// on o_rsp_valid / i_rsp_ready from an output register. Every request gives
// one response with last set, except subset, which gives one response per
// clipped piece (at most MAX_RESULTS), last on the final one.
// A request streams the table once through the head cell: the cells shift
// one step per cycle, save while an insert lands ahead of a stored interval
// or erase splits one, and the head entry is rewritten at the tail. Insert
// and erase first check for a full table across all cells at once. Empty
// ranges, clear, unused codes and a full table go straight to the response.
// A stalled receiver holds the output register; subset then halts the shift
// until its piece is taken. Reset empties the table and drops any response.
// ----------------------------------------------------------------------------
module half_open_interval_set_table
    import hoist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    `include "half_open_interval_set_table_defines.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_PASS, S_RESP} t_state;

    t_state       r_state;
    logic [2:0]   r_cmd;
    logic [63:0]  r_b, r_e, r_mb, r_me, r_pb, r_pe, r_sum;
    logic [CW-1:0] r_count, r_w, r_rem;
    logic [KW-1:0] r_k;
    logic         r_placed, r_half, r_sdone, r_hit;
    logic [1:0]   r_status;
    logic         r_ov;
    t_rsp         r_rsp;

    t_entry       cell_q [CAPACITY];
    t_flags       cell_f [CAPACITY];
    logic [CAPACITY-1:0] touch_m, strad_m;

    logic         deq, wr, slot_free, full, is_empty, nxt_ovl, emit_last;
    t_entry       wdata, head;
    t_flags       hf;
    logic [IW-1:0] widx;
    logic [CW-1:0] w_minus;
    logic [64:0]  sum_x;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry nbr;
            if (g == CAPACITY - 1) begin : g_tail
                assign nbr = cell_q[g];
            end else begin : g_mid
                assign nbr = cell_q[g + 1];
            end
            hoist_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (deq),
                .i_load  (wr && (widx == IW'(g))),
                .i_nbr   (nbr),
                .i_new   (wdata),
                .i_b     (r_b),
                .i_e     (r_e),
                .o_q     (cell_q[g]),
                .o_flags (cell_f[g])
            );
            assign touch_m[g] = cell_f[g].touch && (CW'(g) < r_count);
            assign strad_m[g] = cell_f[g].strad && (CW'(g) < r_count);
        end
    endgenerate

    always_comb begin
        head      = cell_q[0];
        hf        = cell_f[0];
        nxt_ovl   = (r_rem >= CW'(2)) && cell_f[1].ovl;
        emit_last = (r_k == KW'(MAX_RESULTS - 1)) || !nxt_ovl;
        slot_free = !r_ov || i_rsp_ready;
        sum_x     = {1'b0, r_sum} + {1'b0, head.hi - head.lo};
        full      = (r_count == CW'(CAPACITY)) &&
                    ((r_cmd == CMD_INSERT) ? !(|touch_m) : (|strad_m));
        is_empty  = ((i_req.cmd == CMD_INSERT) || (i_req.cmd == CMD_ERASE) ||
                     (i_req.cmd == CMD_INTERSECT) || (i_req.cmd == CMD_SUBSET)) &&
                    (i_req.range_begin >= i_req.range_end);
        deq   = 1'b0;
        wr    = 1'b0;
        wdata = head;
        if (r_state == S_PASS) begin
            if (r_rem == '0) begin
                if (r_cmd == CMD_INSERT && !r_placed) begin
                    wr    = 1'b1;
                    wdata = '{lo: r_mb, hi: r_me};
                end
            end else begin
                case (r_cmd)
                    CMD_INSERT: begin
                        if (hf.touch) begin
                            deq = 1'b1;
                        end else if (!r_placed && head.lo > r_e) begin
                            wr    = 1'b1;
                            wdata = '{lo: r_mb, hi: r_me};
                        end else begin
                            wr  = 1'b1;
                            deq = 1'b1;
                        end
                    end
                    CMD_ERASE: begin
                        if (hf.ovl) begin
                            if (!r_half && head.lo < r_b) begin
                                wr    = 1'b1;
                                wdata = '{lo: head.lo, hi: r_b};
                                deq   = !(head.hi > r_e);
                            end else if (head.hi > r_e) begin
                                wr    = 1'b1;
                                wdata = '{lo: r_e, hi: head.hi};
                                deq   = 1'b1;
                            end else begin
                                deq = 1'b1;
                            end
                        end else begin
                            wr  = 1'b1;
                            deq = 1'b1;
                        end
                    end
                    CMD_SUBSET: begin
                        if (!(hf.ovl && !r_sdone) || slot_free) begin
                            wr  = 1'b1;
                            deq = 1'b1;
                        end
                    end
                    default: begin
                        wr  = 1'b1;
                        deq = 1'b1;
                    end
                endcase
            end
        end
        w_minus = r_w - CW'(deq);
        widx    = w_minus[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_rsp_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd    <= i_req.cmd;
                        r_b      <= i_req.range_begin;
                        r_e      <= i_req.range_end;
                        r_mb     <= i_req.range_begin;
                        r_me     <= i_req.range_end;
                        r_placed <= 1'b0;
                        r_half   <= 1'b0;
                        r_sdone  <= 1'b0;
                        r_hit    <= 1'b0;
                        r_pb     <= '0;
                        r_pe     <= '0;
                        r_sum    <= '0;
                        r_k      <= '0;
                        r_w      <= r_count;
                        r_rem    <= r_count;
                        r_status <= ST_DONE;
                        if (is_empty) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_RESP;
                        end else if (i_req.cmd == CMD_CLEAR) begin
                            r_count <= '0;
                            r_state <= S_RESP;
                        end else if (i_req.cmd == CMD_INSERT || i_req.cmd == CMD_ERASE) begin
                            r_state <= S_CHECK;
                        end else if (i_req.cmd > CMD_CLEAR) begin
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_PASS;
                        end
                    end
                end
                S_CHECK: begin
                    if (full) begin
                        r_status <= ST_FULL;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_w <= w_minus + CW'(wr);
                    if (r_rem == '0) begin
                        r_count <= r_w + CW'(wr);
                        r_state <= (r_cmd == CMD_SUBSET && r_k != '0) ? S_IDLE : S_RESP;
                    end else begin
                        if (deq) begin
                            r_rem <= r_rem - CW'(1);
                        end
                        case (r_cmd)
                            CMD_INSERT: begin
                                if (hf.touch) begin
                                    if (head.lo < r_mb) r_mb <= head.lo;
                                    if (head.hi > r_me) r_me <= head.hi;
                                end else if (!r_placed && head.lo > r_e) begin
                                    r_placed <= 1'b1;
                                end
                            end
                            CMD_ERASE: begin
                                r_half <= wr && !deq;
                            end
                            CMD_LOOKUP: begin
                                if (hf.holds) begin
                                    r_hit <= 1'b1;
                                    r_pb  <= head.lo;
                                    r_pe  <= head.hi;
                                end
                            end
                            CMD_INTERSECT: begin
                                if (hf.ovl) r_hit <= 1'b1;
                            end
                            CMD_TOTAL: begin
                                r_sum <= sum_x[64] ? '1 : sum_x[63:0];
                            end
                            CMD_SUBSET: begin
                                if (hf.ovl && !r_sdone && slot_free) begin
                                    r_ov              <= 1'b1;
                                    r_rsp.status       <= ST_DONE;
                                    r_rsp.hit          <= 1'b1;
                                    r_rsp.piece_begin  <= (head.lo > r_b) ? head.lo : r_b;
                                    r_rsp.piece_end    <= (head.hi < r_e) ? head.hi : r_e;
                                    r_rsp.total_length <= '0;
                                    r_rsp.last         <= emit_last;
                                    r_k                <= r_k + KW'(1);
                                    r_sdone            <= emit_last;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (slot_free) begin
                        r_ov               <= 1'b1;
                        r_rsp.status       <= r_status;
                        r_rsp.hit          <= r_hit;
                        r_rsp.piece_begin  <= r_pb;
                        r_rsp.piece_end    <= r_pe;
                        r_rsp.total_length <= r_sum;
                        r_rsp.last         <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_rsp;

    `HOIST_ASSERT_ALWAYS(a_count_cap, (r_count <= CW'(CAPACITY)), "interval count over capacity")
    `HOIST_ASSERT_ALWAYS(a_chain_room, (!(wr && !deq) || (r_w < CW'(CAPACITY))),
        "cell row overrun")
    `HOIST_ASSERT_NEXT(a_empty_resp, (i_req_valid && o_req_ready && is_empty),
        (r_state == S_RESP && r_status == ST_EMPTY), "empty range not answered")

endmodule
